/* rtl/uuenc_pkg.sv */
// ----------------------------------------------------------------------------
// uuenc_pkg
// Shared constants, types and the character mapping of the uuencode line
// encoder.
// ----------------------------------------------------------------------------
package uuenc_pkg;

	// Bytes per full text line
	localparam int LINE_BYTES = 45;
	// Line buffer address and fill count widths
	localparam int ADDR_W = $clog2(LINE_BYTES);
	localparam int CNT_W  = $clog2(LINE_BYTES + 1);
	// Sum of a count and a small offset, with headroom
	localparam int SUM_W  = CNT_W + 1;

	localparam int BYTE_W = 8;
	localparam int CHAR_W = 7;

	localparam logic [CHAR_W-1:0] CHAR_NEWLINE  = 7'd10;
	localparam logic [CHAR_W-1:0] CHAR_BACKTICK = 7'd96;
	localparam logic [CHAR_W-1:0] CHAR_OFFSET   = 7'd32;

	// One output character and its end-of-line mark
	typedef struct packed {
		logic [CHAR_W-1:0] text_char;
		logic              line_end;
	} uuenc_res_t;

	// 6-bit value to printable character; zero becomes backtick
	function automatic logic [CHAR_W-1:0] uu_char(input logic [5:0] v);
		logic [CHAR_W-1:0] c;
		c = (v == 6'd0) ? CHAR_BACKTICK : ({1'b0, v} + CHAR_OFFSET);
		return c;
	endfunction

endpackage

/* rtl/uuenc_if.sv */
// ----------------------------------------------------------------------------
// uuenc_in_if / uuenc_out_if
// Valid/ready channels for raw data bytes in and text characters out.
// ----------------------------------------------------------------------------
interface uuenc_in_if;
	logic                          valid;
	logic                          ready;
	logic [uuenc_pkg::BYTE_W-1:0]  data_byte;
	logic                          end_of_data;

	modport source (output valid, output data_byte, output end_of_data, input ready);
	modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface uuenc_out_if;
	logic                          valid;
	logic                          ready;
	logic [uuenc_pkg::CHAR_W-1:0]  text_char;
	logic                          line_end;

	modport source (output valid, output text_char, output line_end, input ready);
	modport sink   (input valid, input text_char, input line_end, output ready);
endinterface

/* rtl/uuenc_out_buf.sv */
// ----------------------------------------------------------------------------
// uuenc_out_buf
// Two-entry output queue: decouples the character sequencer from a
// stalling receiver while keeping full rate.
// ----------------------------------------------------------------------------
module uuenc_out_buf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	input  uuenc_pkg::uuenc_res_t push_res,
	output logic                  push_ready,
	uuenc_out_if.source           text_out
);

	uuenc_pkg::uuenc_res_t ent_q [2];
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            count_q;
	logic                  push;
	logic                  pop;

	assign push_ready = (count_q != 2'd2);
	assign push       = push_valid && push_ready;
	assign pop        = text_out.ready && (count_q != 2'd0);

	assign text_out.valid     = (count_q != 2'd0);
	assign text_out.text_char = ent_q[rd_ptr_q].text_char;
	assign text_out.line_end  = ent_q[rd_ptr_q].line_end;

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_res;
		end
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Occupancy never exceeds two entries
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("output queue overfilled");

	// After a push the queue presents a valid character next cycle
	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> text_out.valid)
		else $error("pushed character not presented");

	// Pointers differ exactly when one entry is held
	a_ptr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd1) == (wr_ptr_q != rd_ptr_q))
		else $error("queue pointers out of step with count");

endmodule

/* rtl/uuencode_line_encoder_core.sv */
// ----------------------------------------------------------------------------
// uuencode_line_encoder_core
// Buffers data bytes into lines and emits each line as uuencode text.
// ----------------------------------------------------------------------------
// Usage:
//   data_in  : one data byte per request; end_of_data marks the last byte
//              and flushes a partial line.
//   text_out : one ASCII character per request: the length character, four
//              characters per group of three bytes (zero padded), then a
//              newline with line_end set.
// Bytes are written into a single-port line memory at one per cycle while
// the line fills. On the byte that completes a line (45 bytes) or carries
// end_of_data, data_in drops ready until the whole line has been handed to
// the output queue. The length character is requested in the cycle after
// that byte; each group then reads its bytes from the memory in S_RD (three
// read slots on one port, registered read data) and issues its four
// characters in S_CHR, and the newline follows the last group.
// A stalled receiver holds the two-entry output queue full and the
// sequencer waits; nothing is dropped. Reset empties the line and the
// queue; the line memory is not cleared, since only bytes written for the
// current line are ever read.
// ----------------------------------------------------------------------------
module uuencode_line_encoder_core (
	input  logic        clk,
	input  logic        arst_n,
	uuenc_in_if.sink    data_in,
	uuenc_out_if.source text_out
);

	typedef enum logic [2:0] {
		S_FILL,
		S_LEN,
		S_RD,
		S_CHR,
		S_NL
	} state_t;

	state_t                              state_q;
	logic [uuenc_pkg::CNT_W-1:0]         fill_q;
	logic [uuenc_pkg::CNT_W-1:0]         len_q;
	logic [uuenc_pkg::CNT_W-1:0]         base_q;
	logic [1:0]                          sub_q;
	logic [1:0]                          chr_q;
	logic                                keep_q;
	logic [uuenc_pkg::BYTE_W-1:0]        b0_q;
	logic [uuenc_pkg::BYTE_W-1:0]        b1_q;
	logic [uuenc_pkg::BYTE_W-1:0]        b2_q;

	logic [uuenc_pkg::BYTE_W-1:0]        line_mem [uuenc_pkg::LINE_BYTES];
	logic [uuenc_pkg::BYTE_W-1:0]        rd_data_q;

	logic                                in_acc;
	logic [uuenc_pkg::CNT_W-1:0]         fill_nxt;
	logic                                flush;
	logic [uuenc_pkg::SUM_W-1:0]         rd_sum;
	logic [uuenc_pkg::SUM_W-1:0]         next_base;
	logic                                rd_en;
	logic [uuenc_pkg::ADDR_W-1:0]        rd_addr;
	logic [uuenc_pkg::BYTE_W-1:0]        cap_byte;
	logic [5:0]                          grp_val;
	logic                                push_valid;
	logic                                push_ready;
	uuenc_pkg::uuenc_res_t               push_res;

	// Input side
	assign data_in.ready = (state_q == S_FILL);
	assign in_acc        = data_in.valid && data_in.ready;
	assign fill_nxt      = fill_q + uuenc_pkg::CNT_W'(1);
	assign flush         = (fill_nxt == uuenc_pkg::CNT_W'(uuenc_pkg::LINE_BYTES))
	                       || data_in.end_of_data;

	// Read address for the byte at base + sub
	assign rd_sum    = uuenc_pkg::SUM_W'(base_q) + uuenc_pkg::SUM_W'(sub_q);
	assign rd_addr   = rd_sum[uuenc_pkg::ADDR_W-1:0];
	assign rd_en     = (state_q == S_RD) && (sub_q != 2'd3)
	                   && (rd_sum < uuenc_pkg::SUM_W'(len_q));
	assign next_base = uuenc_pkg::SUM_W'(base_q) + uuenc_pkg::SUM_W'(3);

	// Bytes past the line length read as zero
	assign cap_byte = keep_q ? rd_data_q : '0;

	// Line memory: write while filling, read while encoding
	always_ff @(posedge clk) begin
		if (in_acc) begin
			line_mem[fill_q[uuenc_pkg::ADDR_W-1:0]] <= data_in.data_byte;
		end
		if (rd_en) begin
			rd_data_q <= line_mem[rd_addr];
		end
	end

	// Six-bit value for the current character of a group
	always_comb begin
		case (chr_q)
			2'd0:    grp_val = b0_q[7:2];
			2'd1:    grp_val = {b0_q[1:0], b1_q[7:4]};
			2'd2:    grp_val = {b1_q[3:0], b2_q[7:6]};
			default: grp_val = b2_q[5:0];
		endcase
	end

	// Character request to the output queue
	always_comb begin
		push_valid         = 1'b0;
		push_res.text_char = uuenc_pkg::uu_char(grp_val);
		push_res.line_end  = 1'b0;
		case (state_q)
			S_LEN: begin
				push_valid         = 1'b1;
				push_res.text_char = uuenc_pkg::uu_char(6'(len_q));
			end
			S_CHR: begin
				push_valid = 1'b1;
			end
			S_NL: begin
				push_valid         = 1'b1;
				push_res.text_char = uuenc_pkg::CHAR_NEWLINE;
				push_res.line_end  = 1'b1;
			end
			default: begin
				push_valid = 1'b0;
			end
		endcase
	end

	// Group byte capture (payload, no reset)
	always_ff @(posedge clk) begin
		if (state_q == S_RD) begin
			case (sub_q)
				2'd1:    b0_q <= cap_byte;
				2'd2:    b1_q <= cap_byte;
				2'd3:    b2_q <= cap_byte;
				default: b0_q <= b0_q;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_FILL;
			fill_q  <= '0;
			len_q   <= '0;
			base_q  <= '0;
			sub_q   <= '0;
			chr_q   <= '0;
			keep_q  <= 1'b0;
		end else begin
			keep_q <= rd_en;
			case (state_q)
				S_FILL: begin
					if (in_acc) begin
						if (flush) begin
							len_q   <= fill_nxt;
							fill_q  <= '0;
							state_q <= S_LEN;
						end else begin
							fill_q <= fill_nxt;
						end
					end
				end
				S_LEN: begin
					if (push_ready) begin
						base_q  <= '0;
						sub_q   <= '0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					sub_q <= sub_q + 2'd1;
					if (sub_q == 2'd3) begin
						chr_q   <= '0;
						state_q <= S_CHR;
					end
				end
				S_CHR: begin
					if (push_ready) begin
						chr_q <= chr_q + 2'd1;
						if (chr_q == 2'd3) begin
							base_q <= next_base[uuenc_pkg::CNT_W-1:0];
							sub_q  <= '0;
							if (next_base >= uuenc_pkg::SUM_W'(len_q)) begin
								state_q <= S_NL;
							end else begin
								state_q <= S_RD;
							end
						end
					end
				end
				S_NL: begin
					if (push_ready) begin
						state_q <= S_FILL;
					end
				end
				default: begin
					state_q <= S_FILL;
				end
			endcase
		end
	end

	uuenc_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_res   (push_res),
		.push_ready (push_ready),
		.text_out   (text_out)
	);

	// Fill count stays inside the line while filling
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < uuenc_pkg::CNT_W'(uuenc_pkg::LINE_BYTES))
		else $error("fill count beyond line length");

	// A flagged byte always starts a line flush
	a_eod_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && data_in.end_of_data) |=> (state_q == S_LEN && fill_q == '0))
		else $error("end of data did not flush the line");

	// Group base stays below the line length while encoding
	a_base_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD || state_q == S_CHR) |-> (base_q < len_q))
		else $error("group base past line length");

	// Newline request returns the block to filling
	a_nl_done: assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && push_ready && push_res.line_end) |=> data_in.ready)
		else $error("input not reopened after line end");

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for uuencode_line_encoder_core. A short table of
// byte requests covers the extremes, zero padding and partial groups.
// Random data sets follow, each ending on an end_of_data byte, with random
// gaps on both channels. Every text character is checked in order against
// the typed table characters or a line-buffer predictor.
// ----------------------------------------------------------------------------
module tb_top;
	import uuenc_pkg::*;

	localparam int RANDOM_BYTES = 450;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 120;
	localparam int REPORT_MAX   = 10;

	// Length characters and encoded characters used in the typed rows
	localparam logic [CHAR_W-1:0] CH_LEN1  = 7'd33;	// '!'
	localparam logic [CHAR_W-1:0] CH_LEN2  = 7'd34;	// '"'
	localparam logic [CHAR_W-1:0] CH_LEN3  = 7'd35;	// '#'
	localparam logic [CHAR_W-1:0] CH_HIGH2 = 7'd80;	// 'P', value 0x30
	localparam logic [CHAR_W-1:0] CH_ALL1  = 7'd95;	// '_', value 0x3F

	// One row of the directed table; chars[5] is the first character
	typedef struct {
		logic [BYTE_W-1:0]      data;
		bit                     eod;
		bit                     typed;
		logic [5:0][CHAR_W-1:0] chars;
	} stim_row_t;

	logic clk;
	logic arst_n;

	uuenc_in_if  bytes_ch ();
	uuenc_out_if chars_ch ();

	uuencode_line_encoder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.data_in  (bytes_ch),
		.text_out (chars_ch)
	);

	// Predictor state
	logic [BYTE_W-1:0] line_buf [LINE_BYTES];
	int                line_fill = 0;
	uuenc_res_t        line_chars [$];
	uuenc_res_t        expected_chars [$];

	stim_row_t directed_rows [$];
	bit        no_idle = 1'b0;
	int        fail_count = 0;
	int        idle_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic uuenc_res_t mk_char(input logic [CHAR_W-1:0] c, input logic e);
		uuenc_res_t r;
		r.text_char = c;
		r.line_end  = e;
		return r;
	endfunction

	// 6-bit value to text; zero maps to backtick
	function automatic logic [CHAR_W-1:0] six_to_char(input logic [5:0] v);
		if (v == 6'd0)
			return CHAR_BACKTICK;
		return CHAR_W'(v) + CHAR_OFFSET;
	endfunction

	// Buffer one byte; on a full line or end of data, build the text line
	function automatic void encode_byte(input logic [BYTE_W-1:0] b, input bit eod);
		logic [BYTE_W-1:0] b0, b1, b2;
		int k;
		line_chars.delete();
		line_buf[line_fill] = b;
		line_fill++;
		if (line_fill < LINE_BYTES && !eod)
			return;
		line_chars.push_back(mk_char(six_to_char(6'(line_fill)), 1'b0));
		for (k = 0; k < line_fill; k += 3) begin
			b0 = line_buf[k];
			b1 = (k + 1 < line_fill) ? line_buf[k + 1] : 8'h00;
			b2 = (k + 2 < line_fill) ? line_buf[k + 2] : 8'h00;
			line_chars.push_back(mk_char(six_to_char(b0[7:2]), 1'b0));
			line_chars.push_back(mk_char(six_to_char({b0[1:0], b1[7:4]}), 1'b0));
			line_chars.push_back(mk_char(six_to_char({b1[3:0], b2[7:6]}), 1'b0));
			line_chars.push_back(mk_char(six_to_char(b2[5:0]), 1'b0));
		end
		line_chars.push_back(mk_char(CHAR_NEWLINE, 1'b1));
		line_fill = 0;
	endfunction

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 7);
	endfunction

	function automatic void add_row(input logic [BYTE_W-1:0] d, input bit eod,
			input bit typed, input logic [5:0][CHAR_W-1:0] chars);
		stim_row_t r;
		r.data  = d;
		r.eod   = eod;
		r.typed = typed;
		r.chars = chars;
		directed_rows.push_back(r);
	endfunction

	// Send one byte request; entered and left at a falling edge
	task automatic send_byte(input logic [BYTE_W-1:0] b, input bit eod, input bit typed,
			input logic [5:0][CHAR_W-1:0] chars);
		int gap;
		int i;
		gap = draw_gap();
		if (gap > 0) begin
			bytes_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		bytes_ch.valid       = 1'b1;
		bytes_ch.data_byte   = b;
		bytes_ch.end_of_data = eod;
		do @(posedge clk); while (bytes_ch.ready !== 1'b1);
		encode_byte(b, eod);
		if (typed) begin
			for (i = 5; i >= 0; i--)
				expected_chars.push_back(mk_char(chars[i], i == 0));
		end else begin
			foreach (line_chars[j])
				expected_chars.push_back(line_chars[j]);
		end
		@(negedge clk);
	endtask

	// Stimulus: reset, directed table, random data sets, drain
	initial begin : stimulus
		int len;
		int n;
		int sent;
		int set_idx;
		logic [BYTE_W-1:0] b;
		arst_n               = 1'b0;
		bytes_ch.valid       = 1'b0;
		bytes_ch.data_byte   = '0;
		bytes_ch.end_of_data = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// single bytes at both extremes
		add_row(8'h00, 1'b1, 1'b1, {CH_LEN1, CHAR_BACKTICK, CHAR_BACKTICK, CHAR_BACKTICK,
			CHAR_BACKTICK, CHAR_NEWLINE});
		add_row(8'hFF, 1'b1, 1'b1, {CH_LEN1, CH_ALL1, CH_HIGH2, CHAR_BACKTICK,
			CHAR_BACKTICK, CHAR_NEWLINE});
		// one whole group of ones
		add_row(8'hFF, 1'b0, 1'b0, '0);
		add_row(8'hFF, 1'b0, 1'b0, '0);
		add_row(8'hFF, 1'b1, 1'b1, {CH_LEN3, CH_ALL1, CH_ALL1, CH_ALL1, CH_ALL1,
			CHAR_NEWLINE});
		// two zero bytes, zero padded
		add_row(8'h00, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b1, 1'b1, {CH_LEN2, CHAR_BACKTICK, CHAR_BACKTICK, CHAR_BACKTICK,
			CHAR_BACKTICK, CHAR_NEWLINE});
		// partial second group
		add_row(8'h12, 1'b0, 1'b0, '0);
		add_row(8'h34, 1'b0, 1'b0, '0);
		add_row(8'h56, 1'b0, 1'b0, '0);
		add_row(8'h78, 1'b1, 1'b0, '0);
		add_row(8'h01, 1'b0, 1'b0, '0);
		add_row(8'h80, 1'b1, 1'b0, '0);
		add_row(8'hAA, 1'b0, 1'b0, '0);
		add_row(8'h55, 1'b0, 1'b0, '0);
		add_row(8'hC3, 1'b0, 1'b0, '0);
		add_row(8'h3C, 1'b0, 1'b0, '0);
		add_row(8'hE7, 1'b1, 1'b0, '0);
		add_row(8'h80, 1'b1, 1'b0, '0);

		foreach (directed_rows[r])
			send_byte(directed_rows[r].data, directed_rows[r].eod, directed_rows[r].typed,
				directed_rows[r].chars);

		// Random data sets; the first two hit a flagged full line and a full
		// line followed by a one-byte flush
		sent    = 0;
		set_idx = 0;
		while (sent < RANDOM_BYTES) begin
			case ($urandom_range(0, 9))
				0, 1, 2: len = $urandom_range(1, 6);
				3, 4, 5: len = $urandom_range(7, LINE_BYTES - 1);
				6, 7:    len = LINE_BYTES - 1 + $urandom_range(0, 2);
				default: len = $urandom_range(LINE_BYTES + 2, 2 * LINE_BYTES + 2);
			endcase
			if (set_idx == 0)
				len = LINE_BYTES;
			else if (set_idx == 1)
				len = LINE_BYTES + 1;
			no_idle = ($urandom_range(0, 4) == 0);
			for (n = 0; n < len; n++) begin
				case ($urandom_range(0, 7))
					0:       b = 8'h00;
					1:       b = 8'hFF;
					default: b = BYTE_W'($urandom_range(0, 255));
				endcase
				send_byte(b, n == len - 1, 1'b0, '0);
			end
			sent += len;
			set_idx++;
		end
		no_idle        = 1'b0;
		bytes_ch.valid = 1'b0;

		// Drain: every character in, then a quiet stretch
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_chars.size() == 0)
			$display("** uuencode_line_encoder_core: PASSED **");
		else
			$display("** uuencode_line_encoder_core: FAILED **");
		$finish;
	end

	// Receiver: random stalls before each character request
	initial begin : receiver
		int stall;
		chars_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				chars_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			chars_ch.ready = 1'b1;
			do @(posedge clk); while (chars_ch.valid !== 1'b1);
			@(negedge clk);
		end
	end

	// Check each accepted character against the oldest expectation
	always @(posedge clk) begin
		uuenc_res_t want;
		if (arst_n && chars_ch.valid === 1'b1 && chars_ch.ready === 1'b1) begin
			if (expected_chars.size() == 0) begin
				if (fail_count < REPORT_MAX)
					$display("unexpected char: text_char=%0d line_end=%0b",
						chars_ch.text_char, chars_ch.line_end);
				fail_count++;
			end else begin
				want = expected_chars.pop_front();
				if (chars_ch.text_char !== want.text_char ||
						chars_ch.line_end !== want.line_end) begin
					if (fail_count < REPORT_MAX)
						$display("char mismatch: exp text_char=%0d line_end=%0b, got text_char=%0d line_end=%0b",
							want.text_char, want.line_end,
							chars_ch.text_char, chars_ch.line_end);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: too long with no request accepted on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((bytes_ch.valid === 1'b1 && bytes_ch.ready === 1'b1) ||
					(chars_ch.valid === 1'b1 && chars_ch.ready === 1'b1))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("** uuencode_line_encoder_core: FAILED **");
				$finish;
			end
		end
	end

endmodule

/* uuencode_line_encoder_core.f */
rtl/uuenc_pkg.sv
rtl/uuenc_if.sv
rtl/uuenc_out_buf.sv
rtl/uuencode_line_encoder_core.sv
test/tb_top.sv
